[rtl/core/afmt_pkg.sv]
// Package for the address-filtered mailbox table: sizes, operation and status codes,
// request and response records, and the payload string-copy function.
// No dependencies.
`timescale 1ns / 1ps

package afmt_pkg;

  localparam int SLOTS         = 16;
  localparam int SLOT_W        = 4;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 3;
  localparam int ADDR_W        = 9;
  localparam int BUS_ADDR_W    = 8;
  localparam int PAYLOAD_BYTES = 8;
  localparam int PAYLOAD_W     = 64;
  localparam int CNT_W         = 32;
  localparam int IN_TDATA_W    = 80;
  localparam int OUT_TDATA_W   = 136;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_OPEN   = 3'd2,
    OP_CLOSE  = 3'd3,
    OP_SETADR = 3'd4,
    OP_RECV   = 3'd5,
    OP_READ   = 3'd6,
    OP_TICK   = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BADARG  = 3'd1,
    ST_ALREADY = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_NOTOPEN = 3'd4,
    ST_USED    = 3'd5,
    ST_EMPTY   = 3'd6,
    ST_DROPPED = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    SLOT_ABSENT = 2'd0,
    SLOT_CLOSED = 2'd1,
    SLOT_OPEN   = 2'd2
  } slot_st_e;

  // Packed lowest field last, so the record maps straight onto tdata.
  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [ADDR_W-1:0]    address;
    logic [SLOT_W-1:0]    slot;
    op_e                  op;
  } req_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] msg_payload;
    logic [CNT_W-1:0]     msg_time;
    logic [CNT_W-1:0]     msg_id;
    logic [SLOT_W-1:0]    hit_slot;
    status_e              status;
  } rsp_t;

  // Keep bytes up to the first zero byte; later ones read as zero.
  function automatic logic [PAYLOAD_W-1:0] string_copy(input logic [PAYLOAD_W-1:0] data);
    logic [PAYLOAD_W-1:0] kept;
    logic                 live;
    kept = '0;
    live = 1'b1;
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      if (data[8*b +: 8] == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        kept[8*b +: 8] = data[8*b +: 8];
      end
    end
    return kept;
  endfunction

endpackage

[rtl/core/afmt_engine.sv]
// Slot table, mailboxes and counters; decodes one request per step.
// Depends on afmt_pkg.
`timescale 1ns / 1ps

module afmt_engine import afmt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  slot_st_e              state_q  [SLOTS];
  logic [BUS_ADDR_W-1:0] addr_q   [SLOTS];
  logic [SLOTS-1:0]      assigned_q;
  logic [SLOTS-1:0]      valid_q;
  logic [CNT_W-1:0]      frame_q;
  logic [CNT_W-1:0]      tick_q;

  // mailbox contents, meaningful only while valid_q is set
  logic [CNT_W-1:0]      mb_id_q   [SLOTS];
  logic [CNT_W-1:0]      mb_time_q [SLOTS];
  logic [PAYLOAD_W-1:0]  mb_data_q [SLOTS];

  logic [SLOTS-1:0]      match;
  logic [SLOT_W-1:0]     hit_idx;
  logic                  any_match;
  logic [BUS_ADDR_W-1:0] cmp_addr;
  slot_st_e              cur_st;
  logic                  slot_ok;

  logic                  st_we;
  slot_st_e              st_new;
  logic                  clr_slot;
  logic                  addr_we;
  logic                  mail_we;
  logic                  frame_inc;
  logic                  tick_inc;

  assign cmp_addr = req_i.address[BUS_ADDR_W-1:0];
  assign cur_st   = state_q[req_i.slot];
  assign slot_ok  = (int'(req_i.slot) < SLOTS);

  // open slots holding the requested address
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = (state_q[i] == SLOT_OPEN) && assigned_q[i] && (addr_q[i] == cmp_addr);
    end
  end

  // lowest matching slot wins
  always_comb begin
    hit_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = SLOT_W'(i);
      end
    end
  end

  assign any_match = |match;

  always_comb begin
    rsp_o     = '0;
    st_we     = 1'b0;
    st_new    = SLOT_ABSENT;
    clr_slot  = 1'b0;
    addr_we   = 1'b0;
    mail_we   = 1'b0;
    frame_inc = 1'b0;
    tick_inc  = 1'b0;
    if (req_i.op == OP_RECV) begin
      frame_inc = 1'b1;
      if (any_match) begin
        rsp_o.status   = ST_OK;
        rsp_o.hit_slot = hit_idx;
        mail_we        = 1'b1;
      end else begin
        rsp_o.status = ST_DROPPED;
      end
    end else if (req_i.op == OP_TICK) begin
      tick_inc = 1'b1;
    end else if (!slot_ok) begin
      rsp_o.status = ST_BADARG;
    end else begin
      unique case (req_i.op)
        OP_ADD: begin
          if (cur_st != SLOT_ABSENT) begin
            rsp_o.status = ST_BADARG;
          end else begin
            st_we    = 1'b1;
            st_new   = SLOT_CLOSED;
            clr_slot = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (cur_st == SLOT_ABSENT) begin
            rsp_o.status = ST_ABSENT;
          end else begin
            st_we    = 1'b1;
            st_new   = SLOT_ABSENT;
            clr_slot = 1'b1;
          end
        end
        OP_OPEN: begin
          if (cur_st == SLOT_OPEN) begin
            rsp_o.status = ST_ALREADY;
          end else if (cur_st == SLOT_ABSENT) begin
            rsp_o.status = ST_ABSENT;
          end else begin
            st_we  = 1'b1;
            st_new = SLOT_OPEN;
          end
        end
        OP_CLOSE: begin
          if (cur_st == SLOT_OPEN) begin
            st_we  = 1'b1;
            st_new = SLOT_CLOSED;
          end else begin
            rsp_o.status = ST_NOTOPEN;
          end
        end
        OP_SETADR: begin
          if (req_i.address[ADDR_W-1:BUS_ADDR_W] != '0) begin
            rsp_o.status = ST_BADARG;
          end else if (cur_st == SLOT_ABSENT) begin
            rsp_o.status = ST_ABSENT;
          end else if (any_match) begin
            rsp_o.status = ST_USED;
          end else begin
            addr_we = 1'b1;
          end
        end
        OP_READ: begin
          if (!valid_q[req_i.slot]) begin
            rsp_o.status = ST_EMPTY;
          end else begin
            rsp_o.msg_id      = mb_id_q[req_i.slot];
            rsp_o.msg_time    = mb_time_q[req_i.slot];
            rsp_o.msg_payload = mb_data_q[req_i.slot];
          end
        end
        OP_RECV, OP_TICK: begin
          rsp_o.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        state_q[i] <= SLOT_ABSENT;
        addr_q[i]  <= '0;
      end
      assigned_q <= '0;
      valid_q    <= '0;
      frame_q    <= '0;
      tick_q     <= '0;
    end else if (step_i) begin
      if (st_we) begin
        state_q[req_i.slot] <= st_new;
      end
      if (clr_slot) begin
        addr_q[req_i.slot]     <= '0;
        assigned_q[req_i.slot] <= 1'b0;
        valid_q[req_i.slot]    <= 1'b0;
      end
      if (addr_we) begin
        addr_q[req_i.slot]     <= cmp_addr;
        assigned_q[req_i.slot] <= 1'b1;
      end
      if (mail_we) begin
        valid_q[hit_idx] <= 1'b1;
      end
      if (frame_inc) begin
        frame_q <= frame_q + CNT_W'(1);
      end
      if (tick_inc) begin
        tick_q <= tick_q + CNT_W'(1);
      end
    end
  end

  // mailbox payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (step_i && mail_we) begin
      mb_id_q[hit_idx]   <= frame_q;
      mb_time_q[hit_idx] <= tick_q;
      mb_data_q[hit_idx] <= string_copy(req_i.payload);
    end
  end

`ifndef NO_ASSERTIONS
  a_recv_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_i.op == OP_RECV && rsp_o.status == ST_OK |=> valid_q[$past(hit_idx)])
    else $error("delivered frame did not mark its mailbox valid");

  a_frame_id : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_i.op == OP_RECV |=> frame_q == $past(frame_q) + CNT_W'(1))
    else $error("frame id not advanced on receive");

  a_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_i.op == OP_TICK |=> tick_q == $past(tick_q) + CNT_W'(1))
    else $error("tick count not advanced");

  a_hit_only_recv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && rsp_o.hit_slot != '0 |-> req_i.op == OP_RECV && rsp_o.status == ST_OK)
    else $error("hit slot reported outside a delivered frame");
`endif

endmodule

[rtl/core/address_filtered_mailbox_table_core.sv]
// Top level of the address-filtered mailbox table: stream handshakes, input and
// result registers around the slot engine. Depends on afmt_pkg and afmt_engine.
`timescale 1ns / 1ps

//  channel   | direction | tdata fields (low bit up)                        | width
//  ----------+-----------+--------------------------------------------------+------
//  s_axis    | in        | operation, slot, address, payload                | 80
//  m_axis    | out       | status, hit_slot, msg_id, msg_time, msg_payload  | 136
//
// One transaction per cycle sustained while m_axis is ready. The input register loads at
// the accept edge and the engine result is registered once the result register is free,
// so m_axis_tvalid rises after the s_axis accept. Table state updates at the same edge
// the result is registered, so the next transaction always sees it. Reset (rst_ni, async,
// active low) empties both registers, marks every slot absent and clears both counters;
// mailbox data is left unreset. A stalled m_axis holds the result and backs up into
// s_axis only once the input register is also full.

module address_filtered_mailbox_table_core import afmt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // operation, slot, address, payload
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // status, hit_slot, msg_id, msg_time,
                                                // msg_payload, one zero pad bit
);

  logic in_v_q, in_v_d;
  req_t in_q;
  logic out_v_q, out_v_d;
  rsp_t out_q;
  rsp_t rsp;
  logic out_free;
  logic step;
  logic in_take;

  // result register can load when empty or being drained this cycle
  assign out_free      = !out_v_q || m_axis_tready;
  assign step          = in_v_q && out_free;
  assign s_axis_tready = !in_v_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_v_d = in_v_q;
    if (in_take) begin
      in_v_d = 1'b1;
    end else if (step) begin
      in_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (step) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= req_t'(s_axis_tdata);
    end
    if (step) begin
      out_q <= rsp;
    end
  end

  afmt_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_q),
    .rsp_o  (rsp)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_q};

endmodule

[tb/sv/address_filtered_mailbox_table_core_tb.sv]
// Self-checking bench for address_filtered_mailbox_table_core: directed slot and frame
// cases, then biased random traffic with random stalls on both streams.
// Depends on afmt_pkg and the core RTL.
`timescale 1ns / 1ps

module address_filtered_mailbox_table_core_tb;
  import afmt_pkg::*;

  localparam int RANDOM_ITEMS = 1025;
  localparam int CYCLE_LIMIT  = 200_000;

  // Shadow of the slot table; predicts one reply per transaction and checks
  // replies in order.
  class mailbox_table_checker;
    slot_st_e              slot_mode[SLOTS];
    logic [BUS_ADDR_W-1:0] bus_addr[SLOTS];
    bit                    addr_set[SLOTS];
    bit                    mail_full[SLOTS];
    logic [CNT_W-1:0]      mail_frame[SLOTS];
    logic [CNT_W-1:0]      mail_tick[SLOTS];
    logic [PAYLOAD_W-1:0]  mail_bytes[SLOTS];
    logic [CNT_W-1:0]      next_frame_id;
    logic [CNT_W-1:0]      tick_now;
    rsp_t                  expected_replies[$];
    int                    failures;
    int                    checked;
    int                    stored;
    int                    dropped;
    int                    delivered;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_mode[i] = SLOT_ABSENT;
        bus_addr[i]  = '0;
        addr_set[i]  = 1'b0;
        mail_full[i] = 1'b0;
      end
      next_frame_id = '0;
      tick_now      = '0;
      failures      = 0;
      checked       = 0;
      stored        = 0;
      dropped       = 0;
      delivered     = 0;
    endfunction

    // Bytes past the first NUL are stored as zero.
    function logic [PAYLOAD_W-1:0] clip_at_nul(logic [PAYLOAD_W-1:0] raw);
      logic [PAYLOAD_W-1:0] head;
      head = '0;
      for (int b = 0; b < PAYLOAD_BYTES; b++) begin
        if (raw[8*b +: 8] == 8'h00) break;
        head[8*b +: 8] = raw[8*b +: 8];
      end
      return head;
    endfunction

    function bit address_taken(logic [BUS_ADDR_W-1:0] value);
      for (int i = 0; i < SLOTS; i++)
        if (slot_mode[i] == SLOT_OPEN && addr_set[i] && bus_addr[i] == value) return 1'b1;
      return 1'b0;
    endfunction

    function void note_request(req_t r);
      rsp_t want;
      int   s;
      want = '0;
      want.status = ST_OK;
      s = int'(r.slot);
      case (r.op)
        OP_RECV: begin
          // id is consumed whether or not a slot takes the frame
          want.status = ST_DROPPED;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_mode[i] == SLOT_OPEN && addr_set[i] && bus_addr[i] == r.address[7:0]) begin
              mail_frame[i] = next_frame_id;
              mail_tick[i]  = tick_now;
              mail_bytes[i] = clip_at_nul(r.payload);
              mail_full[i]  = 1'b1;
              want.status   = ST_OK;
              want.hit_slot = SLOT_W'(i);
              break;
            end
          end
          next_frame_id = next_frame_id + 1;
          if (want.status == ST_OK) stored++;
          else dropped++;
        end
        OP_TICK: tick_now = tick_now + 1;
        OP_ADD: begin
          if (slot_mode[s] != SLOT_ABSENT) begin
            want.status = ST_BADARG;
          end else begin
            slot_mode[s] = SLOT_CLOSED;
            addr_set[s]  = 1'b0;
            bus_addr[s]  = '0;
            mail_full[s] = 1'b0;
          end
        end
        OP_REMOVE: begin
          if (slot_mode[s] == SLOT_ABSENT) begin
            want.status = ST_ABSENT;
          end else begin
            slot_mode[s] = SLOT_ABSENT;
            addr_set[s]  = 1'b0;
            bus_addr[s]  = '0;
            mail_full[s] = 1'b0;
          end
        end
        OP_OPEN: begin
          if (slot_mode[s] == SLOT_OPEN) want.status = ST_ALREADY;
          else if (slot_mode[s] == SLOT_ABSENT) want.status = ST_ABSENT;
          else slot_mode[s] = SLOT_OPEN;
        end
        OP_CLOSE: begin
          if (slot_mode[s] == SLOT_OPEN) slot_mode[s] = SLOT_CLOSED;
          else want.status = ST_NOTOPEN;
        end
        OP_SETADR: begin
          if (r.address > 9'd255) begin
            want.status = ST_BADARG;
          end else if (slot_mode[s] == SLOT_ABSENT) begin
            want.status = ST_ABSENT;
          end else if (address_taken(r.address[7:0])) begin
            want.status = ST_USED;
          end else begin
            bus_addr[s] = r.address[7:0];
            addr_set[s] = 1'b1;
          end
        end
        default: begin  // OP_READ: slot state does not matter, mailbox stays full
          if (!mail_full[s]) begin
            want.status = ST_EMPTY;
          end else begin
            want.msg_id      = mail_frame[s];
            want.msg_time    = mail_tick[s];
            want.msg_payload = mail_bytes[s];
            delivered++;
          end
        end
      endcase
      expected_replies.push_back(want);
    endfunction

    function void check_reply(rsp_t got);
      rsp_t want;
      if (expected_replies.size() == 0) begin
        $error("result with no transaction outstanding: %h", got);
        failures++;
        return;
      end
      want = expected_replies.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
      if (got.hit_slot !== want.hit_slot) begin
        $error("hit_slot: expected %0d, got %0d", want.hit_slot, got.hit_slot);
        failures++;
      end
      if (got.msg_id !== want.msg_id) begin
        $error("msg_id: expected %h, got %h", want.msg_id, got.msg_id);
        failures++;
      end
      if (got.msg_time !== want.msg_time) begin
        $error("msg_time: expected %h, got %h", want.msg_time, got.msg_time);
        failures++;
      end
      if (got.msg_payload !== want.msg_payload) begin
        $error("msg_payload: expected %h, got %h", want.msg_payload, got.msg_payload);
        failures++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // operation, slot, address, payload
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // status, hit_slot, msg_id, msg_time, msg_payload

  mailbox_table_checker tracker;
  int                   sent_count;
  int                   cycles;

  address_filtered_mailbox_table_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Window of back-to-back traffic with no stalls on either side.
  function automatic bit calm_window();
    return sent_count >= 400 && sent_count < 600;
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= calm_window() || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_reply(rsp_t'(m_axis_tdata[$bits(rsp_t)-1:0]));
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one transaction, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_request(input req_t r);
    while (!calm_window() && $urandom_range(0, 99) < 33) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(r);
    sent_count++;
  endtask

  task automatic issue(input op_e op, input int slot, input int addr,
                       input logic [PAYLOAD_W-1:0] payload);
    req_t r;
    r.op      = op;
    r.slot    = SLOT_W'(slot);
    r.address = ADDR_W'(addr);
    r.payload = payload;
    send_request(r);
  endtask

  // Biased traffic: a handful of bus addresses so frames often match an open slot.
  function automatic req_t make_random_request();
    req_t r;
    int   pick;
    int   k;
    pick      = $urandom_range(0, 99);
    r.slot    = SLOT_W'($urandom_range(0, SLOTS - 1));
    r.address = ADDR_W'($urandom_range(0, 511));
    r.payload = {$urandom, $urandom};
    if (pick < 12)      r.op = OP_ADD;
    else if (pick < 17) r.op = OP_REMOVE;
    else if (pick < 29) r.op = OP_OPEN;
    else if (pick < 34) r.op = OP_CLOSE;
    else if (pick < 46) r.op = OP_SETADR;
    else if (pick < 74) r.op = OP_RECV;
    else if (pick < 90) r.op = OP_READ;
    else                r.op = OP_TICK;
    if ((r.op == OP_RECV || r.op == OP_SETADR) && $urandom_range(0, 9) < 9) begin
      case ($urandom_range(0, 5))
        0:       r.address[7:0] = 8'h00;
        1:       r.address[7:0] = 8'hFF;
        2:       r.address[7:0] = 8'h01;
        3:       r.address[7:0] = 8'h80;
        4:       r.address[7:0] = 8'h55;
        default: r.address[7:0] = 8'hAA;
      endcase
      // bit 8 is ignored by receive; for set address it stays rare
      r.address[8] = (r.op == OP_RECV) ? 1'($urandom_range(0, 1)) : 1'b0;
    end
    if ($urandom_range(0, 9) < 3) begin
      k = $urandom_range(0, PAYLOAD_BYTES - 1);
      r.payload[8*k +: 8] = 8'h00;
    end
    return r;
  endfunction

  initial begin
    tracker       = new();
    sent_count    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every operation and every status code.
    issue(OP_ADD,    0,  0,     64'h0);
    issue(OP_ADD,    0,  0,     64'h0);                    // already present
    issue(OP_OPEN,   3,  0,     64'h0);                    // absent slot
    issue(OP_SETADR, 0,  511,   64'h0);                    // address out of range
    issue(OP_SETADR, 0,  256,   64'h0);
    issue(OP_SETADR, 5,  'h55,  64'h0);                    // absent slot
    issue(OP_SETADR, 0,  'h55,  64'h0);
    issue(OP_CLOSE,  0,  0,     64'h0);                    // closed, not open
    issue(OP_OPEN,   0,  0,     64'h0);
    issue(OP_OPEN,   0,  0,     64'h0);                    // already open
    issue(OP_RECV,   9,  'h55,  64'h1122_3300_4455_6677);  // NUL in the middle
    issue(OP_READ,   0,  0,     64'h0);
    issue(OP_TICK,   0,  0,     64'h0);
    issue(OP_RECV,   0,  'h155, 64'hFFFF_FFFF_FFFF_FFFF);  // high address bit ignored
    issue(OP_RECV,   0,  'hAA,  64'h1);                    // no match
    issue(OP_ADD,    15, 0,     64'h0);
    issue(OP_SETADR, 15, 'hFF,  64'h0);
    issue(OP_OPEN,   15, 0,     64'h0);
    issue(OP_SETADR, 15, 'h55,  64'h0);                    // held by another open slot
    issue(OP_SETADR, 15, 'hFF,  64'h0);                    // held by the slot itself
    issue(OP_RECV,   0,  'hFF,  64'hFFFF_FFFF_FFFF_FF00);  // NUL in the first byte
    issue(OP_READ,   15, 0,     64'h0);
    issue(OP_REMOVE, 0,  0,     64'h0);
    issue(OP_REMOVE, 0,  0,     64'h0);                    // already absent
    issue(OP_READ,   0,  0,     64'h0);                    // emptied by remove
    issue(OP_CLOSE,  15, 0,     64'h0);
    issue(OP_CLOSE,  15, 0,     64'h0);

    for (int n = 0; n < RANDOM_ITEMS; n++) send_request(make_random_request());

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.expected_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d transactions, checked %0d replies in %0d cycles.",
             sent_count, tracker.checked, cycles);
    $display("Frames stored %0d, dropped %0d; reads returning a message %0d.",
             tracker.stored, tracker.dropped, tracker.delivered);
    if (tracker.failures == 0 && tracker.expected_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/afmt_pkg.sv
rtl/core/afmt_engine.sv
rtl/core/address_filtered_mailbox_table_core.sv
tb/sv/address_filtered_mailbox_table_core_tb.sv
